// ===== rtl/cnsp_pkg.sv =====
package cnsp_pkg;

   localparam logic [31:0] HdrLen          = 32'd110;
   localparam logic [31:0] MagicLen        = 32'd6;
   localparam logic [31:0] ModeFirst       = 32'd14;
   localparam logic [31:0] ModeLast        = 32'd21;
   localparam logic [31:0] FileSizeFirst   = 32'd54;
   localparam logic [31:0] FileSizeLast    = 32'd61;
   localparam logic [31:0] NameSizeFirst   = 32'd94;
   localparam logic [31:0] NameSizeLast    = 32'd101;
   localparam logic [31:0] TrailerLen      = 32'd10;
   localparam logic [31:0] TrailerNameSize = 32'd11;

   localparam logic [3:0] ModeTypeReg  = 4'b1000;
   localparam logic [3:0] ModeTypeDir  = 4'b0100;
   localparam logic [3:0] ModeTypeLink = 4'b1010;

   typedef enum logic [2:0] {
      ROLE_HEADER      = 3'd0,
      ROLE_NAME        = 3'd1,
      ROLE_NAME_PAD    = 3'd2,
      ROLE_FILE_DATA   = 3'd3,
      ROLE_LINK_TARGET = 3'd4,
      ROLE_SKIPPED     = 3'd5,
      ROLE_DATA_PAD    = 3'd6,
      ROLE_IGNORED     = 3'd7
   } role_type;

   typedef enum logic [1:0] {
      KIND_REGULAR = 2'd0,
      KIND_DIR     = 2'd1,
      KIND_SYMLINK = 2'd2,
      KIND_UNKNOWN = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_MAGIC     = 2'd1,
      ERR_FORMAT    = 2'd2,
      ERR_DIR_DATA  = 2'd3
   } error_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      role_type    byte_role;
      kind_type    entry_kind;
      logic [8:0]  permissions;
      logic [31:0] entry_size;
      logic [31:0] name_length;
      logic        entry_ready;
      logic        entry_last;
      logic        archive_end;
      error_type   error_code;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic logic [7:0] magic_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = "0";
         3'd1: c = "7";
         3'd2: c = "0";
         3'd3: c = "7";
         3'd4: c = "0";
         3'd5: c = "1";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] trailer_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0: c = "T";
         4'd1: c = "R";
         4'd2: c = "A";
         4'd3: c = "I";
         4'd4: c = "L";
         4'd5: c = "E";
         4'd6: c = "R";
         4'd7: c = "!";
         4'd8: c = "!";
         4'd9: c = "!";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b0;
      h.value = 4'd0;
      if (c >= "0" && c <= "9") begin
         h.ok    = 1'b1;
         h.value = 4'(c - 8'h30);
      end else if (c >= "a" && c <= "f") begin
         h.ok    = 1'b1;
         h.value = 4'(c - 8'h57);
      end else if (c >= "A" && c <= "F") begin
         h.ok    = 1'b1;
         h.value = 4'(c - 8'h37);
      end
      return h;
   endfunction

   function automatic kind_type kind_of_mode(input logic [31:0] mode);
      kind_type k;
      if (mode[15:12] == ModeTypeReg) begin
         k = KIND_REGULAR;
      end else if (mode[15:12] == ModeTypeDir) begin
         k = KIND_DIR;
      end else if (mode[15:12] == ModeTypeLink) begin
         k = KIND_SYMLINK;
      end else begin
         k = KIND_UNKNOWN;
      end
      return k;
   endfunction

endpackage

// ===== rtl/cnsp_in_stage.sv =====
module cnsp_in_stage
   import cnsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       take,
   output logic       hold_valid,
   output logic [7:0] hold_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         byte_in  = req_data_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

endmodule

// ===== rtl/cnsp_parse_core.sv =====
module cnsp_parse_core
   import cnsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   output result_type result
);

   typedef enum logic [6:0] {
      PH_HEADER   = 7'b0000001,
      PH_NAME     = 7'b0000010,
      PH_NAMEPAD  = 7'b0000100,
      PH_DATA     = 7'b0001000,
      PH_DATAPAD  = 7'b0010000,
      PH_DONE     = 7'b0100000,
      PH_FAILED   = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] nsize_ff, nsize_in;
   logic [31:0] mode_ff, mode_in;
   logic [31:0] fsize_ff, fsize_in;
   logic        tmatch_ff, tmatch_in;
   logic        hfault_ff, hfault_in;
   logic        done_ff, done_in;
   error_type   err_ff, err_in;

   hex_type     hx;
   kind_type    kind_now;
   role_type    role;
   logic [1:0]  name_pad;
   logic [1:0]  data_pad;
   logic        show_name, show_entry, ready_flag, last_flag;
   logic        end_name, end_data, hdr_fail;

   assign hx       = hex_decode(data_byte);
   assign kind_now = kind_of_mode(mode_ff);
   assign name_pad = 2'd0 - (nsize_ff[1:0] + 2'd2);
   assign data_pad = 2'd0 - fsize_ff[1:0];

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      nsize_in   = nsize_ff;
      mode_in    = mode_ff;
      fsize_in   = fsize_ff;
      tmatch_in  = tmatch_ff;
      hfault_in  = hfault_ff;
      done_in    = done_ff;
      err_in     = err_ff;
      role       = ROLE_IGNORED;
      show_name  = 1'b0;
      show_entry = 1'b0;
      ready_flag = 1'b0;
      last_flag  = 1'b0;
      end_name   = 1'b0;
      end_data   = 1'b0;
      hdr_fail   = 1'b0;

      unique case (phase_ff) inside
         PH_HEADER: begin
            role = ROLE_HEADER;
            if (pos_ff == 32'd0) begin
               nsize_in  = 32'd0;
               mode_in   = 32'd0;
               fsize_in  = 32'd0;
               tmatch_in = 1'b1;
               hfault_in = 1'b0;
            end
            if (pos_ff < MagicLen) begin
               if (data_byte != magic_char(pos_ff[2:0])) begin
                  err_in   = ERR_MAGIC;
                  hdr_fail = 1'b1;
               end
            end else if (pos_ff >= ModeFirst && pos_ff <= ModeLast) begin
               if (hx.ok) begin
                  mode_in = {mode_ff[27:0], hx.value};
               end else begin
                  hfault_in = 1'b1;
               end
            end else if (pos_ff >= FileSizeFirst && pos_ff <= FileSizeLast) begin
               if (hx.ok) begin
                  fsize_in = {fsize_ff[27:0], hx.value};
               end else begin
                  hfault_in = 1'b1;
               end
            end else if (pos_ff >= NameSizeFirst && pos_ff <= NameSizeLast) begin
               if (hx.ok) begin
                  nsize_in = {nsize_ff[27:0], hx.value};
               end else begin
                  err_in   = ERR_FORMAT;
                  hdr_fail = 1'b1;
               end
            end
            if (hdr_fail) begin
               phase_in = PH_FAILED;
            end else if (pos_ff == HdrLen - 32'd1) begin
               if (nsize_ff == 32'd0) begin
                  err_in   = ERR_FORMAT;
                  phase_in = PH_FAILED;
               end else begin
                  phase_in = PH_NAME;
                  pos_in   = 32'd0;
               end
            end else begin
               pos_in = pos_ff + 32'd1;
            end
         end
         PH_NAME: begin
            role      = ROLE_NAME;
            show_name = 1'b1;
            if (pos_ff < TrailerLen && data_byte != trailer_char(pos_ff[3:0])) begin
               tmatch_in = 1'b0;
            end
            if (pos_ff == nsize_ff - 32'd1) begin
               if (name_pad == 2'd0) begin
                  end_name = 1'b1;
               end else begin
                  phase_in = PH_NAMEPAD;
                  pos_in   = 32'd0;
               end
            end else begin
               pos_in = pos_ff + 32'd1;
            end
         end
         PH_NAMEPAD: begin
            role      = ROLE_NAME_PAD;
            show_name = 1'b1;
            if (pos_ff + 32'd1 >= {30'd0, name_pad}) begin
               end_name = 1'b1;
            end else begin
               pos_in = pos_ff + 32'd1;
            end
         end
         PH_DATA: begin
            if (kind_now == KIND_REGULAR) begin
               role = ROLE_FILE_DATA;
            end else if (kind_now == KIND_SYMLINK) begin
               role = ROLE_LINK_TARGET;
            end else begin
               role = ROLE_SKIPPED;
            end
            show_name  = 1'b1;
            show_entry = 1'b1;
            if (pos_ff == fsize_ff - 32'd1) begin
               if (data_pad == 2'd0) begin
                  end_data = 1'b1;
               end else begin
                  phase_in = PH_DATAPAD;
                  pos_in   = 32'd0;
               end
            end else begin
               pos_in = pos_ff + 32'd1;
            end
         end
         PH_DATAPAD: begin
            role       = ROLE_DATA_PAD;
            show_name  = 1'b1;
            show_entry = 1'b1;
            if (pos_ff + 32'd1 >= {30'd0, data_pad}) begin
               end_data = 1'b1;
            end else begin
               pos_in = pos_ff + 32'd1;
            end
         end
         PH_DONE, PH_FAILED: begin
            role = ROLE_IGNORED;
         end
         default: begin
            role = ROLE_IGNORED;
         end
      endcase

      if (end_name) begin
         if (nsize_ff == TrailerNameSize && tmatch_in) begin
            done_in   = 1'b1;
            last_flag = 1'b1;
            phase_in  = PH_DONE;
         end else if (hfault_ff) begin
            err_in   = ERR_FORMAT;
            phase_in = PH_FAILED;
         end else if (kind_now == KIND_DIR && fsize_ff != 32'd0) begin
            err_in   = ERR_DIR_DATA;
            phase_in = PH_FAILED;
         end else begin
            ready_flag = 1'b1;
            show_entry = 1'b1;
            pos_in     = 32'd0;
            if (fsize_ff != 32'd0) begin
               phase_in = PH_DATA;
            end else begin
               last_flag = 1'b1;
               phase_in  = PH_HEADER;
            end
         end
      end

      if (end_data) begin
         last_flag = 1'b1;
         phase_in  = PH_HEADER;
         pos_in    = 32'd0;
      end
   end

   always_comb begin
      result.byte_out    = data_byte;
      result.byte_role   = role;
      result.entry_kind  = show_entry ? kind_now : KIND_REGULAR;
      result.permissions = show_entry ? mode_ff[8:0] : 9'd0;
      result.entry_size  = show_entry ? fsize_ff : 32'd0;
      result.name_length = show_name ? nsize_ff : 32'd0;
      result.entry_ready = ready_flag;
      result.entry_last  = last_flag;
      result.archive_end = done_in;
      result.error_code  = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= 32'd0;
         nsize_ff  <= 32'd0;
         mode_ff   <= 32'd0;
         fsize_ff  <= 32'd0;
         tmatch_ff <= 1'b1;
         hfault_ff <= 1'b0;
         done_ff   <= 1'b0;
         err_ff    <= ERR_NONE;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         nsize_ff  <= nsize_in;
         mode_ff   <= mode_in;
         fsize_ff  <= fsize_in;
         tmatch_ff <= tmatch_in;
         hfault_ff <= hfault_in;
         done_ff   <= done_in;
         err_ff    <= err_in;
      end
   end

endmodule

// ===== rtl/cnsp_out_stage.sv =====
module cnsp_out_stage
   import cnsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result_next,
   output logic       space,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type result_held
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result_next;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign result_held = data_ff;

endmodule

// ===== rtl/cpio_newc_stream_parser_unit.sv =====
// An input beat is held in the input register and then in the result register before the
// result side can take its result beat.
// Throughput: one byte per cycle while the result side keeps taking beats.
// Synchronous active-high reset returns the parser to the start of a header
// and clears all errors, the end-of-archive flag and both pipeline registers.
module cpio_newc_stream_parser_unit
   import cnsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_out,
   output logic [2:0]  rsp_byte_role,
   output logic [1:0]  rsp_entry_kind,
   output logic [8:0]  rsp_permissions,
   output logic [31:0] rsp_entry_size,
   output logic [31:0] rsp_name_length,
   output logic        rsp_entry_ready,
   output logic        rsp_entry_last,
   output logic        rsp_archive_end,
   output logic [1:0]  rsp_error_code
);

   logic       hold_valid;
   logic [7:0] hold_byte;
   logic       space;
   logic       step;
   result_type result_next;
   result_type result_held;

   assign step = hold_valid && space;

   cnsp_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .take          (step),
      .hold_valid    (hold_valid),
      .hold_byte     (hold_byte)
   );

   cnsp_parse_core u_parse_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (hold_byte),
      .result    (result_next)
   );

   cnsp_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (step),
      .result_next (result_next),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .result_held (result_held)
   );

   assign rsp_byte_out    = result_held.byte_out;
   assign rsp_byte_role   = result_held.byte_role;
   assign rsp_entry_kind  = result_held.entry_kind;
   assign rsp_permissions = result_held.permissions;
   assign rsp_entry_size  = result_held.entry_size;
   assign rsp_name_length = result_held.name_length;
   assign rsp_entry_ready = result_held.entry_ready;
   assign rsp_entry_last  = result_held.entry_last;
   assign rsp_archive_end = result_held.archive_end;
   assign rsp_error_code  = result_held.error_code;

endmodule

// ===== rtl/cnsp_checker.sv =====
module cnsp_checker
   import cnsp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_byte_out,
   input logic [2:0]  rsp_byte_role,
   input logic [31:0] rsp_entry_size,
   input logic [31:0] rsp_name_length,
   input logic        rsp_entry_ready,
   input logic        rsp_archive_end,
   input logic [1:0]  rsp_error_code
);

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_out)
         && $stable(rsp_byte_role) && $stable(rsp_error_code))
      else $error("result beat changed while stalled");

   // An entry is announced only at the end of its name region, without error.
   a_ready_ctx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_ready |->
         (rsp_byte_role == ROLE_NAME || rsp_byte_role == ROLE_NAME_PAD)
         && rsp_error_code == ERR_NONE && !rsp_archive_end)
      else $error("entry announced outside a clean name region");

   // Data and data padding beats belong to an accepted entry with content.
   a_data_ctx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_role == ROLE_FILE_DATA || rsp_byte_role == ROLE_LINK_TARGET
         || rsp_byte_role == ROLE_SKIPPED || rsp_byte_role == ROLE_DATA_PAD) |->
         rsp_entry_size != 32'd0 && rsp_error_code == ERR_NONE
         && rsp_name_length != 32'd0)
      else $error("data beat without a valid entry");

   // Header beats carry no entry information.
   a_header_ctx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_role == ROLE_HEADER |->
         rsp_name_length == 32'd0 && rsp_entry_size == 32'd0 && !rsp_entry_ready)
      else $error("header beat carries entry fields");

endmodule

bind cpio_newc_stream_parser_unit cnsp_checker u_cnsp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_byte_out    (rsp_byte_out),
   .rsp_byte_role   (rsp_byte_role),
   .rsp_entry_size  (rsp_entry_size),
   .rsp_name_length (rsp_name_length),
   .rsp_entry_ready (rsp_entry_ready),
   .rsp_archive_end (rsp_archive_end),
   .rsp_error_code  (rsp_error_code)
);
